@@ design/bgd_pkg.sv @@
`timescale 1ns / 1ps

package bgd_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int MAX_PRESSES = 15;

    localparam int REG_W   = 16;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = $clog2(MAX_PRESSES + 1);
    localparam int CMP_W   = (TIMER_WIDTH > REG_W) ? TIMER_WIDTH : REG_W;
    localparam int ACT_W   = 3;
    localparam int TOTAL_W = 4;
    localparam int PHASE_W = 2;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
    localparam logic [CNT_W-1:0]       CNT_MAX   = CNT_W'(MAX_PRESSES);

    typedef enum logic [IDX_W-1:0] {
        REG_SHORT_PRESS = 8'd0,
        REG_LONG_PRESS  = 8'd1,
        REG_DIMMER_STEP = 8'd2,
        REG_PRESS_GAP   = 8'd3
    } t_reg_idx;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_ON       = 3'd1,
        ACT_OFF      = 3'd2,
        ACT_MULTI    = 3'd3,
        ACT_FADE_IN  = 3'd4,
        ACT_FADE_OUT = 3'd5
    } t_action;

    typedef enum logic [PHASE_W-1:0] {
        PH_CODE_IDLE = 2'd0,
        PH_CODE_HELD = 2'd1,
        PH_CODE_DIM  = 2'd2,
        PH_CODE_NEXT = 2'd3
    } t_phase_code;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_HELD = 4'b0010,
        ST_DIM  = 4'b0100,
        ST_NEXT = 4'b1000
    } t_state;

    typedef struct packed {
        logic [REG_W-1:0] short_press_ms;
        logic [REG_W-1:0] long_press_ms;
        logic [REG_W-1:0] dimmer_step_ms;
        logic [REG_W-1:0] press_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic button_down;
        logic brightness_at_min;
        logic brightness_at_max;
    } t_tick;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [TOTAL_W-1:0] press_total;
        logic               fade_up;
        logic [PHASE_W-1:0] gesture_phase;
    } t_result;

endpackage

@@ design/bgd_if.sv @@
`timescale 1ns / 1ps

interface bgd_in_if;
    logic valid;
    logic ready;
    logic button_down;
    logic brightness_at_min;
    logic brightness_at_max;

    modport source (output valid, output button_down, output brightness_at_min,
                    output brightness_at_max, input ready);
    modport sink   (input valid, input button_down, input brightness_at_min,
                    input brightness_at_max, output ready);
endinterface

interface bgd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [3:0] press_total;
    logic       fade_up;
    logic [1:0] gesture_phase;

    modport source (output valid, output action, output press_total, output fade_up,
                    output gesture_phase, input ready);
    modport sink   (input valid, input action, input press_total, input fade_up,
                    input gesture_phase, output ready);
endinterface

interface bgd_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/button_gesture_decoder_top.sv @@
`timescale 1ns / 1ps
// channel   | dir | handshake              | payload
// i_in      | in  | valid / ready          | button_down, brightness_at_min, brightness_at_max
// o_out     | out | valid / ready          | action, press_total, fade_up, gesture_phase
// i_cfg     | in  | valid / ready (always) | index (8 bits), data (16 bits)
//
// one tick per cycle sustained while o_out is ready
// an input register feeds the gesture logic, whose result lands in the output register
// the input register refills whenever it is empty; both hold while the result waits
// i_rst_n is synchronous: state goes idle, counters clear, fade direction to fade in

module button_gesture_decoder_top
    import bgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bgd_in_if.sink      i_in,
    bgd_out_if.source   o_out,
    bgd_cfg_if.sink     i_cfg
);

    logic    r_in_valid;
    t_tick   r_tick;
    logic    r_out_valid;
    logic    w_advance;
    logic    w_step;
    t_cfg    w_cfg;
    t_result w_result;

    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_tick.button_down       <= i_in.button_down;
            r_tick.brightness_at_min <= i_in.brightness_at_min;
            r_tick.brightness_at_max <= i_in.brightness_at_max;
        end
    end

    bgd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    bgd_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_tick   (r_tick),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.action        = w_result.action;
    assign o_out.press_total   = w_result.press_total;
    assign o_out.fade_up       = w_result.fade_up;
    assign o_out.gesture_phase = w_result.gesture_phase;

endmodule

@@ design/bgd_cfg_regs.sv @@
`timescale 1ns / 1ps

module bgd_cfg_regs
    import bgd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [IDX_W-1:0] i_index,
    input  logic [REG_W-1:0] i_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (t_reg_idx'(i_index))
                REG_SHORT_PRESS: n_cfg.short_press_ms = i_data;
                REG_LONG_PRESS:  n_cfg.long_press_ms  = i_data;
                REG_DIMMER_STEP: n_cfg.dimmer_step_ms = i_data;
                REG_PRESS_GAP:   n_cfg.press_gap_ms   = i_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_press_ms <= REG_W'(50);
            r_cfg.long_press_ms  <= REG_W'(800);
            r_cfg.dimmer_step_ms <= REG_W'(50);
            r_cfg.press_gap_ms   <= REG_W'(400);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/bgd_fsm.sv @@
`timescale 1ns / 1ps

module bgd_fsm
    import bgd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_tick   i_tick,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_state                 r_state,   n_state;
    logic [TIMER_WIDTH-1:0] r_elapsed, n_elapsed;
    logic [CNT_W-1:0]       r_count,   n_count;
    logic                   r_fade,    n_fade;
    t_result                r_result,  n_result;

    logic [TIMER_WIDTH-1:0] w_tick_time;
    logic [CMP_W-1:0]       w_time_ext;
    logic                   w_gt_short;
    logic                   w_gt_long;
    logic                   w_gt_step;
    logic                   w_gt_gap;
    t_action                w_act;
    t_phase_code            w_phase_code;

    assign w_tick_time = (r_elapsed == TIMER_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign w_time_ext  = CMP_W'(w_tick_time);
    assign w_gt_short  = w_time_ext > CMP_W'(i_cfg.short_press_ms);
    assign w_gt_long   = w_time_ext > CMP_W'(i_cfg.long_press_ms);
    assign w_gt_step   = w_time_ext > CMP_W'(i_cfg.dimmer_step_ms);
    // a press on the expiry tick zeroes the timer, so the run goes on
    assign w_gt_gap    = !i_tick.button_down && (w_time_ext > CMP_W'(i_cfg.press_gap_ms));

    always_comb begin
        n_state   = r_state;
        n_elapsed = w_tick_time;
        n_count   = r_count;
        n_fade    = r_fade;
        w_act     = ACT_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_tick.button_down) begin
                    n_elapsed = '0;
                    n_state   = ST_HELD;
                end
            end
            ST_HELD: begin
                if (!i_tick.button_down) begin
                    if (w_gt_short || (r_count != '0)) begin
                        n_state   = ST_NEXT;
                        n_elapsed = '0;
                        if (r_count < CNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (w_gt_long) begin
                    n_state   = ST_DIM;
                    n_elapsed = '0;
                    if (i_tick.brightness_at_max) begin
                        n_fade = 1'b0;
                    end else if (i_tick.brightness_at_min) begin
                        n_fade = 1'b1;
                    end
                end
            end
            ST_DIM: begin
                if (!i_tick.button_down) begin
                    n_count = '0;
                    n_fade  = !r_fade;
                    n_state = ST_IDLE;
                end
                if (w_gt_step) begin
                    w_act     = n_fade ? ACT_FADE_IN : ACT_FADE_OUT;
                    n_elapsed = '0;
                end
            end
            ST_NEXT: begin
                if (i_tick.button_down) begin
                    n_elapsed = '0;
                    n_state   = ST_HELD;
                end
                if (w_gt_gap) begin
                    if (r_count == CNT_W'(1)) begin
                        w_act = i_tick.brightness_at_min ? ACT_ON : ACT_OFF;
                    end else begin
                        w_act  = ACT_MULTI;
                        n_fade = 1'b0;
                    end
                    n_count = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        case (n_state)
            ST_IDLE: w_phase_code = PH_CODE_IDLE;
            ST_HELD: w_phase_code = PH_CODE_HELD;
            ST_DIM:  w_phase_code = PH_CODE_DIM;
            ST_NEXT: w_phase_code = PH_CODE_NEXT;
            default: w_phase_code = PH_CODE_IDLE;
        endcase
    end

    always_comb begin
        n_result.action        = w_act;
        n_result.press_total   = TOTAL_W'(n_count);
        n_result.fade_up       = n_fade;
        n_result.gesture_phase = w_phase_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_elapsed <= '0;
            r_count   <= '0;
            r_fade    <= 1'b1;
        end else if (i_step) begin
            r_state   <= n_state;
            r_elapsed <= n_elapsed;
            r_count   <= n_count;
            r_fade    <= n_fade;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

@@ design/bgd_checker.sv @@
`timescale 1ns / 1ps

module bgd_checker
    import bgd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [ACT_W-1:0]   i_action,
    input logic [TOTAL_W-1:0] i_press_total,
    input logic               i_fade_up,
    input logic [PHASE_W-1:0] i_gesture_phase
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_action)
            && $stable(i_press_total) && $stable(i_gesture_phase) && $stable(i_fade_up))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a resolved run leaves the machine idle with no presses
    a_resolve_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action == ACT_ON || i_action == ACT_OFF || i_action == ACT_MULTI)
            |-> i_gesture_phase == PH_CODE_IDLE && i_press_total == '0)
        else $error("resolution without return to idle");

    a_multi_fade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_action == ACT_MULTI |-> !i_fade_up)
        else $error("multi-press did not clear fade direction");

    // steps only while dimming or on the release tick, matching the direction
    a_step_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action == ACT_FADE_IN || i_action == ACT_FADE_OUT)
            |-> (i_gesture_phase == PH_CODE_DIM || i_gesture_phase == PH_CODE_IDLE)
                && (i_fade_up == (i_action == ACT_FADE_IN)))
        else $error("dimmer step out of place");

endmodule

bind button_gesture_decoder_top bgd_checker u_bgd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_action        (o_out.action),
    .i_press_total   (o_out.press_total),
    .i_fade_up       (o_out.fade_up),
    .i_gesture_phase (o_out.gesture_phase)
);
